// File: rtl/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DIM_W          = 9;     // brick size plus mortar, up to 270
  localparam int HASH_W         = 32;
  localparam int MOD_W          = 10;
  localparam int HashMod        = 1000;

  // ceil(2^38 / 1000): (h * RECIP_1000) >> RECIP_SHIFT is h / 1000 for any 32-bit h
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  typedef enum logic [2:0] {
    CFG_ENABLE       = 3'd0,
    CFG_BRICK_WIDTH  = 3'd1,
    CFG_BRICK_HEIGHT = 3'd2,
    CFG_MORTAR_SIZE  = 3'd3,
    CFG_SPARSITY     = 3'd4,
    CFG_LONG_LINE    = 3'd5,
    CFG_CLASS_LIMITS = 3'd6,
    CFG_COLOR_GAINS  = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CLS_NONE     = 3'd0,
    CLS_MORTAR   = 3'd1,
    CLS_DARK     = 3'd2,
    CLS_LIGHT    = 3'd3,
    CLS_OUTLINE  = 3'd4,
    CLS_INTERIOR = 3'd5
  } shade_cls_t;

  localparam logic        RST_ENABLE       = 1'b1;
  localparam logic [7:0]  RST_BRICK_WIDTH  = 8'd8;
  localparam logic [7:0]  RST_BRICK_HEIGHT = 8'd4;
  localparam logic [3:0]  RST_MORTAR_SIZE  = 4'd1;
  localparam logic [15:0] RST_SPARSITY     = 16'd65535;
  localparam logic [9:0]  RST_LONG_LINE    = 10'd50;
  localparam logic [29:0] RST_CLASS_LIMITS = 30'd314777700;
  localparam logic [47:0] RST_COLOR_GAINS  = 48'd10587950755968;

  localparam logic [11:0] GAIN_UNITY = 12'd256;

endpackage
`default_nettype wire

// File: rtl/brick_pattern_pixel_shader.sv
`timescale 1ns / 1ps
`default_nettype none
// Running-bond brick shader: one pixel transaction per clock, one result per pixel, in order.
// The row and column divisions run as chains of one-bit restoring division cells, one cell
// per quotient bit; the hash, its quotients by 1000 (reciprocal multiply) and the two
// remainders take one register each, and the shading multiply lands in the output
// register. A side register behind the output catches one result when out_tready drops, so
// in_tready is registered and falls once a result arrives while the output stalls; the whole
// chain holds while that side register is full.
// Write configuration only while no pixel is in flight.
module brick_pattern_pixel_shader #(
  parameter int COORD_BITS = bps_pkg::COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pos_x[15:0], pos_y[31:16], random_sample[47:32], in_red[55:48],
  // in_green[63:56], in_blue[71:64]
  input  wire logic [71:0] in_tdata,
  // is_rock[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [23:0]      out_tdata,
  // shade_class[2:0]
  output logic [2:0]       out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [47:0] cfg_wdata
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = bps_pkg::DIM_W;
  localparam int MW    = bps_pkg::MOD_W;
  localparam int HW    = bps_pkg::HASH_W;
  localparam int PW1   = 1 + CB + 24;
  localparam int PW2   = 1 + CB + DW + 24;
  localparam int PW3   = 1 + 2 * DW;
  localparam int RS    = bps_pkg::RECIP_SHIFT;

  logic        enable_r;
  logic [7:0]  bw_r;
  logic [7:0]  bh_r;
  logic [3:0]  ms_r;
  logic [15:0] sparse_r;
  logic [9:0]  chance_r;
  logic [29:0] climits_r;
  logic [47:0] gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= bps_pkg::RST_ENABLE;
      bw_r      <= bps_pkg::RST_BRICK_WIDTH;
      bh_r      <= bps_pkg::RST_BRICK_HEIGHT;
      ms_r      <= bps_pkg::RST_MORTAR_SIZE;
      sparse_r  <= bps_pkg::RST_SPARSITY;
      chance_r  <= bps_pkg::RST_LONG_LINE;
      climits_r <= bps_pkg::RST_CLASS_LIMITS;
      gains_r   <= bps_pkg::RST_COLOR_GAINS;
    end else if (cfg_we) begin
      case (bps_pkg::cfg_idx_t'(cfg_addr))
        bps_pkg::CFG_ENABLE:       enable_r  <= cfg_wdata[0];
        bps_pkg::CFG_BRICK_WIDTH:  bw_r      <= cfg_wdata[7:0];
        bps_pkg::CFG_BRICK_HEIGHT: bh_r      <= cfg_wdata[7:0];
        bps_pkg::CFG_MORTAR_SIZE:  ms_r      <= cfg_wdata[3:0];
        bps_pkg::CFG_SPARSITY:     sparse_r  <= cfg_wdata[15:0];
        bps_pkg::CFG_LONG_LINE:    chance_r  <= cfg_wdata[9:0];
        bps_pkg::CFG_CLASS_LIMITS: climits_r <= cfg_wdata[29:0];
        bps_pkg::CFG_COLOR_GAINS:  gains_r   <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  // geometry from configuration
  logic [7:0]    wq;
  logic [7:0]    hq;
  logic [DW-1:0] tw;
  logic [DW-1:0] th;
  logic [7:0]    half_tw;

  always_comb begin
    wq      = (bw_r == 8'd0) ? 8'd1 : bw_r;
    hq      = (bh_r == 8'd0) ? 8'd1 : bh_r;
    tw      = {1'b0, wq} + {5'b0, ms_r};
    th      = {1'b0, hq} + {5'b0, ms_r};
    half_tw = tw[DW-1:1];
  end

  logic adv;
  logic skid_valid_r;
  assign adv       = !skid_valid_r;
  assign in_tready = adv;

  // input unpack
  logic [CB-1:0] xc;
  logic [CB-1:0] yc;
  logic          active_in;

  if (CB <= 16) begin : g_crd_narrow
    assign xc = in_tdata[CB-1:0];
    assign yc = in_tdata[16+CB-1:16];
  end else begin : g_crd_wide
    assign xc = {{(CB-16){1'b0}}, in_tdata[15:0]};
    assign yc = {{(CB-16){1'b0}}, in_tdata[31:16]};
  end

  assign active_in = enable_r && in_tuser && (in_tdata[47:32] <= sparse_r);

  // row = y / th, ym = y % th
  logic          v1;
  logic [CB-1:0] row1;
  logic [DW-1:0] ym1;
  logic [PW1-1:0] p1;

  bps_div_chain #(.N(CB), .DW(DW), .PW(PW1)) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .dividend  (yc),
    .divisor   (th),
    .pay_in    ({active_in, xc, in_tdata[71:48]}),
    .out_valid (v1),
    .quotient  (row1),
    .remainder (ym1),
    .pay_out   (p1)
  );

  // shift odd rows by half a cell
  logic [CB:0] xs;
  assign xs = {1'b0, p1[PW1-2 -: CB]} +
              (row1[0] ? (CB+1)'(half_tw) : '0);

  logic           v2;
  logic [CB:0]    col2;
  logic [DW-1:0]  xm2;
  logic [PW2-1:0] p2;

  bps_div_chain #(.N(CB+1), .DW(DW), .PW(PW2)) u_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v1),
    .dividend  (xs),
    .divisor   (tw),
    .pay_in    ({p1[PW1-1], row1, ym1, p1[23:0]}),
    .out_valid (v2),
    .quotient  (col2),
    .remainder (xm2),
    .pay_out   (p2)
  );

  // hash = row*13 + col*23 modulo 2^32
  logic [HW-1:0] r32;
  logic [HW-1:0] c32;
  logic [HW-1:0] hsh;

  always_comb begin
    r32 = HW'(p2[PW2-2 -: CB]);
    c32 = HW'(col2);
    hsh = (r32 << 3) + (r32 << 2) + r32 +
          (c32 << 4) + (c32 << 2) + (c32 << 1) + c32;
  end

  logic           va_r;
  logic [HW-1:0]  ha_r;
  logic [PW3-1:0] pay_a_r;
  logic [23:0]    rgb_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ha_r    <= hsh;
      pay_a_r <= {p2[PW2-1], xm2, p2[DW+23:24]};
      rgb_a_r <= p2[23:0];
    end
  end

  // quotients of hash and hash >> 8 by 1000; only their low bits are kept
  logic [60:0] prod_a;
  logic [60:0] prod_b;

  always_comb begin
    prod_a = {29'b0, ha_r} * {32'b0, bps_pkg::RECIP_1000};
    prod_b = {37'b0, ha_r[HW-1:8]} * {32'b0, bps_pkg::RECIP_1000};
  end

  logic           vb_r;
  logic [17:0]    hlo_r;
  logic [6:0]     qa_r;
  logic [6:0]     qb_r;
  logic [PW3-1:0] pay_b_r;
  logic [23:0]    rgb_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hlo_r   <= ha_r[17:0];
      qa_r    <= prod_a[RS +: 7];
      qb_r    <= prod_b[RS +: 7];
      pay_b_r <= pay_a_r;
      rgb_b_r <= rgb_a_r;
    end
  end

  // remainder = h - 1000*q; modulo 1024 that is h + 24*q, and it is below 1000
  logic [MW-1:0] rmain_nxt;
  logic [MW-1:0] rtype_nxt;

  always_comb begin
    rmain_nxt = hlo_r[9:0] + {qa_r[5:0], 4'b0} + {qa_r, 3'b0};
    rtype_nxt = hlo_r[17:8] + {qb_r[5:0], 4'b0} + {qb_r, 3'b0};
  end

  logic           vc_r;
  logic [MW-1:0]  rmain_r;
  logic [MW-1:0]  rtype_r;
  logic [PW3-1:0] pay_c_r;
  logic [23:0]    rgb_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rmain_r <= rmain_nxt;
      rtype_r <= rtype_nxt;
      pay_c_r <= pay_b_r;
      rgb_c_r <= rgb_b_r;
    end
  end

  // classify and shade
  logic              active3;
  logic [DW-1:0]     xm3;
  logic [DW-1:0]     ym3;
  logic signed [11:0] xi;
  logic signed [11:0] yi;
  logic signed [11:0] m12;
  logic signed [11:0] wlim;
  logic signed [11:0] hlim;
  logic              mortar;
  logic              edge_px;
  logic [10:0]       ll;
  logic [11:0]       bl;
  logic [10:0]       msum;
  bps_pkg::shade_cls_t cls;
  logic [11:0]       gain;
  logic [19:0]       pr;
  logic [19:0]       pg;
  logic [19:0]       pb;
  logic [7:0]        sr;
  logic [7:0]        sg;
  logic [7:0]        sb;

  always_comb begin
    active3 = pay_c_r[PW3-1];
    xm3     = pay_c_r[2*DW-1:DW];
    ym3     = pay_c_r[DW-1:0];
    m12     = $signed({8'b0, ms_r});
    xi      = $signed({3'b0, xm3}) - m12;
    yi      = $signed({3'b0, ym3}) - m12;
    wlim    = $signed({4'b0, wq}) - (m12 <<< 1);
    hlim    = $signed({4'b0, hq}) - (m12 <<< 1);
    ll      = {1'b0, climits_r[9:0]} + {1'b0, climits_r[19:10]};
    bl      = {1'b0, ll} + {2'b0, climits_r[29:20]};
    msum    = {1'b0, rmain_r} + {1'b0, chance_r};
    mortar  = (xm3 < {5'b0, ms_r}) || (ym3 < {5'b0, ms_r});
    if (!mortar) begin
      if ((rmain_r < chance_r) && (yi >= hlim)) mortar = 1'b1;
      if ((msum > 11'(bps_pkg::HashMod)) && (xi >= wlim)) mortar = 1'b1;
    end
    edge_px = (xi < m12) || (yi < m12) || (xi >= wlim) || (yi >= hlim);
    cls     = bps_pkg::CLS_NONE;
    gain    = bps_pkg::GAIN_UNITY;
    if (active3) begin
      if (mortar) begin
        cls  = bps_pkg::CLS_MORTAR;
        gain = gains_r[11:0];
      end else if ({1'b0, rtype_r} < {1'b0, climits_r[9:0]}) begin
        cls  = bps_pkg::CLS_DARK;
        gain = gains_r[23:12];
      end else if ({1'b0, rtype_r} < ll) begin
        cls  = bps_pkg::CLS_LIGHT;
        gain = gains_r[35:24];
      end else if ({2'b0, rtype_r} < bl) begin
        if (edge_px) begin
          cls  = bps_pkg::CLS_OUTLINE;
          gain = gains_r[47:36];
        end else begin
          cls  = bps_pkg::CLS_INTERIOR;
        end
      end
    end
    // unity gain leaves the channel as it is
    pr = {12'b0, rgb_c_r[7:0]}   * {8'b0, gain};
    pg = {12'b0, rgb_c_r[15:8]}  * {8'b0, gain};
    pb = {12'b0, rgb_c_r[23:16]} * {8'b0, gain};
    sr = (pr[19:16] != 4'd0) ? 8'hFF : pr[15:8];
    sg = (pg[19:16] != 4'd0) ? 8'hFF : pg[15:8];
    sb = (pb[19:16] != 4'd0) ? 8'hFF : pb[15:8];
  end

  logic        out_valid_r;
  logic [23:0] odata_r;
  logic [2:0]  ouser_r;
  logic [23:0] skid_data_r;
  logic [2:0]  skid_user_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  // the side register takes the result that arrives while the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || vc_r;
      skid_valid_r <= 1'b0;
    end else if (adv && vc_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      odata_r <= skid_valid_r ? skid_data_r : {sb, sg, sr};
      ouser_r <= skid_valid_r ? skid_user_r : cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_free && adv) begin
      skid_data_r <= {sb, sg, sr};
      skid_user_r <= cls;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule
`default_nettype wire

// File: rtl/bps_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bps_div_cell #(
  parameter int N  = 16,
  parameter int DW = 9,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          val_i,
  input  wire logic [N-1:0]  quo_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [DW-1:0] dvs_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               val_o,
  output logic [N-1:0]       quo_o,
  output logic [DW-1:0]      rem_o,
  output logic [DW-1:0]      dvs_o,
  output logic [PW-1:0]      pay_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [N-1:0]  quo_nxt;
  logic          val_r;
  logic [N-1:0]  quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [PW-1:0] pay_r;

  // bring down the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_i, quo_i[N-1]};
    diff    = trial - {1'b0, dvs_i};
    ge      = trial >= {1'b0, dvs_i};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_nxt = {quo_i[N-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else if (adv) begin
      val_r <= val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      pay_r <= pay_i;
    end
  end

  assign val_o = val_r;
  assign quo_o = quo_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign pay_o = pay_r;

endmodule
`default_nettype wire

// File: rtl/bps_div_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module bps_div_chain #(
  parameter int N  = 16,
  parameter int DW = 9,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire logic [N-1:0]  dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [PW-1:0] pay_in,
  output logic               out_valid,
  output logic [N-1:0]       quotient,
  output logic [DW-1:0]      remainder,
  output logic [PW-1:0]      pay_out
);

  logic          val [0:N];
  logic [N-1:0]  quo [0:N];
  logic [DW-1:0] rem [0:N];
  logic [DW-1:0] dvs [0:N];
  logic [PW-1:0] pay [0:N];

  assign val[0] = in_valid;
  assign quo[0] = dividend;
  assign rem[0] = '0;
  assign dvs[0] = divisor;
  assign pay[0] = pay_in;

  for (genvar k = 0; k < N; k++) begin : g_cell
    bps_div_cell #(.N(N), .DW(DW), .PW(PW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .val_i (val[k]),
      .quo_i (quo[k]),
      .rem_i (rem[k]),
      .dvs_i (dvs[k]),
      .pay_i (pay[k]),
      .val_o (val[k+1]),
      .quo_o (quo[k+1]),
      .rem_o (rem[k+1]),
      .dvs_o (dvs[k+1]),
      .pay_o (pay[k+1])
    );
  end

  assign out_valid = val[N];
  assign quotient  = quo[N];
  assign remainder = rem[N];
  assign pay_out   = pay[N];

endmodule
`default_nettype wire

// File: verif/tb_brick_pattern_pixel_shader.sv
`timescale 1ns / 1ps
module tb_brick_pattern_pixel_shader;

  localparam int LATENCY     = 2 * 16 + 5;
  localparam int HOLD_CYCLES = 8 * LATENCY;
  localparam int WDOG_MAX    = 5000;
  localparam int N_RANDOM    = 850;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic        rock;
    logic [15:0] rnd;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [2:0] cls;
  } shaded_t;

  typedef struct {
    pixel_t     pix;
    logic       has_exp;
    logic [7:0] r, g, b;
    bps_pkg::shade_cls_t cls;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [47:0] cfg_wdata = '0;

  // shadow copy of the register file
  logic        sh_enable;
  logic [7:0]  sh_width, sh_height;
  logic [3:0]  sh_mortar;
  logic [15:0] sh_sparse;
  logic [9:0]  sh_chance;
  logic [29:0] sh_limits;
  logic [47:0] sh_gains;

  shaded_t pending_q[$];
  vec_t    vec_tbl[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;

  brick_pattern_pixel_shader u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_vec(vec_t v);
    vec_tbl = {vec_tbl, v};
  endfunction

  function automatic void queue_exp(shaded_t s);
    pending_q = {pending_q, s};
  endfunction

  function automatic logic [7:0] apply_gain(logic [7:0] c, logic [11:0] gain);
    logic [19:0] p;
    p = c * gain;
    return (p[19:8] > 12'd255) ? 8'd255 : p[15:8];
  endfunction

  function automatic shaded_t shade_pixel(pixel_t p);
    shaded_t res;
    logic [11:0] gain;
    int unsigned w, h, m, tw, th, row, xs, xm, ym, col, hh, rmain, rtype, dl, ll, bl;
    int xi, yi;
    bit mortar;
    gain = bps_pkg::GAIN_UNITY;
    res.cls = bps_pkg::CLS_NONE;
    if (sh_enable && p.rock && p.rnd <= sh_sparse) begin
      w = (sh_width == 0) ? 1 : sh_width;
      h = (sh_height == 0) ? 1 : sh_height;
      m = sh_mortar;
      tw = w + m;
      th = h + m;
      row = p.py / th;
      xs = p.px + (row[0] ? tw / 2 : 0);
      xm = xs % tw;
      ym = p.py % th;
      col = xs / tw;
      hh = row * 13 + col * 23;
      rmain = hh % 1000;
      rtype = (hh >> 8) % 1000;
      xi = int'(xm) - int'(m);
      yi = int'(ym) - int'(m);
      mortar = (xm < m) || (ym < m);
      dl = sh_limits[9:0];
      ll = dl + sh_limits[19:10];
      bl = ll + sh_limits[29:20];
      if (!mortar) begin
        if (rmain < sh_chance && yi >= int'(h) - 2 * int'(m)) mortar = 1;
        if (rmain + sh_chance > 1000 && xi >= int'(w) - 2 * int'(m)) mortar = 1;
      end
      if (mortar) begin
        res.cls = bps_pkg::CLS_MORTAR;
        gain = sh_gains[11:0];
      end else if (rtype < dl) begin
        res.cls = bps_pkg::CLS_DARK;
        gain = sh_gains[23:12];
      end else if (rtype < ll) begin
        res.cls = bps_pkg::CLS_LIGHT;
        gain = sh_gains[35:24];
      end else if (rtype < bl) begin
        if (xi < int'(m) || yi < int'(m) || xi >= int'(w) - 2 * int'(m)
            || yi >= int'(h) - 2 * int'(m)) begin
          res.cls = bps_pkg::CLS_OUTLINE;
          gain = sh_gains[47:36];
        end else begin
          res.cls = bps_pkg::CLS_INTERIOR;
        end
      end
    end
    res.r = (gain == bps_pkg::GAIN_UNITY) ? p.r : apply_gain(p.r, gain);
    res.g = (gain == bps_pkg::GAIN_UNITY) ? p.g : apply_gain(p.g, gain);
    res.b = (gain == bps_pkg::GAIN_UNITY) ? p.b : apply_gain(p.b, gain);
    return res;
  endfunction

  task automatic write_reg(bps_pkg::cfg_idx_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bps_pkg::CFG_ENABLE:       sh_enable = val[0];
      bps_pkg::CFG_BRICK_WIDTH:  sh_width = val[7:0];
      bps_pkg::CFG_BRICK_HEIGHT: sh_height = val[7:0];
      bps_pkg::CFG_MORTAR_SIZE:  sh_mortar = val[3:0];
      bps_pkg::CFG_SPARSITY:     sh_sparse = val[15:0];
      bps_pkg::CFG_LONG_LINE:    sh_chance = val[9:0];
      bps_pkg::CFG_CLASS_LIMITS: sh_limits = val[29:0];
      bps_pkg::CFG_COLOR_GAINS:  sh_gains = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // send one transaction; in_tvalid stays high between back-to-back items
  task automatic send_pixel(pixel_t p, shaded_t exp_val);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {p.b, p.g, p.r, p.rnd, p.py, p.px};
    in_tuser <= p.rock;
    do @(posedge clk); while (!in_tready);
    queue_exp(exp_val);
    @(negedge clk);
  endtask

  task automatic send_checked(pixel_t p);
    send_pixel(p, shade_pixel(p));
  endtask

  function automatic pixel_t rand_pixel(bit favor_rock);
    pixel_t p;
    p = pixel_t'(81'({$urandom, $urandom, $urandom}));
    if (favor_rock && $urandom_range(0, 9) != 0) p.rock = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      p.px = 16'($urandom_range(0, 600));
      p.py = 16'($urandom_range(0, 600));
    end
    return p;
  endfunction

  task automatic random_cfg;
    write_reg(bps_pkg::CFG_ENABLE, 48'($urandom_range(0, 7) != 0));
    write_reg(bps_pkg::CFG_BRICK_WIDTH, 48'(($urandom_range(0, 4) == 0) ?
                                            $urandom_range(0, 255) : $urandom_range(0, 20)));
    write_reg(bps_pkg::CFG_BRICK_HEIGHT, 48'(($urandom_range(0, 4) == 0) ?
                                             $urandom_range(0, 255) : $urandom_range(0, 20)));
    write_reg(bps_pkg::CFG_MORTAR_SIZE, 48'($urandom_range(0, 15)));
    write_reg(bps_pkg::CFG_SPARSITY, 48'(($urandom_range(0, 1) != 0) ?
                                         32'hFFFF : $urandom_range(0, 65535)));
    write_reg(bps_pkg::CFG_LONG_LINE, 48'($urandom_range(0, 1023)));
    write_reg(bps_pkg::CFG_CLASS_LIMITS, 48'({10'($urandom_range(0, 400)),
                                              10'($urandom_range(0, 400)),
                                              10'($urandom_range(0, 400))}));
    write_reg(bps_pkg::CFG_COLOR_GAINS, 48'({$urandom, $urandom}));
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else begin
        stall = $urandom_range(0, 3);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
      end
    end
  end

  // scoreboard
  always @(posedge clk) begin
    shaded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected transaction %h/%0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[7:0] !== want.r) begin
          $error("out_red: expected %0d, got %0d", want.r, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== want.g) begin
          $error("out_green: expected %0d, got %0d", want.g, out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[23:16] !== want.b) begin
          $error("out_blue: expected %0d, got %0d", want.b, out_tdata[23:16]);
          errors++;
        end
        if (out_tuser !== want.cls) begin
          $error("shade_class: expected %0d, got %0d", want.cls, out_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || stim_done || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("brick_pattern_pixel_shader regression: fail");
      $finish;
    end
  end

  initial begin
    vec_t   v;
    shaded_t e;
    int     k;
    sh_enable = bps_pkg::RST_ENABLE;
    sh_width = bps_pkg::RST_BRICK_WIDTH;
    sh_height = bps_pkg::RST_BRICK_HEIGHT;
    sh_mortar = bps_pkg::RST_MORTAR_SIZE;
    sh_sparse = bps_pkg::RST_SPARSITY;
    sh_chance = bps_pkg::RST_LONG_LINE;
    sh_limits = bps_pkg::RST_CLASS_LIMITS;
    sh_gains = bps_pkg::RST_COLOR_GAINS;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed table; has_exp rows carry an obvious answer
    add_vec('{'{16'd5, 16'd1, 1'b0, 16'd0, 8'd0, 8'd128, 8'd255},
              1, 0, 128, 255, bps_pkg::CLS_NONE});
    add_vec('{'{16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 8'd255, 8'd255, 8'd255},
              1, 255, 255, 255, bps_pkg::CLS_NONE});
    add_vec('{'{16'd0, 16'd0, 1'b1, 16'd0, 8'd255, 8'd1, 8'd77},
              0, 0, 0, 0, bps_pkg::CLS_NONE});
    add_vec('{'{16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'd200, 8'd100, 8'd50},
              0, 0, 0, 0, bps_pkg::CLS_NONE});
    for (k = 0; k < 14; k++)
      add_vec('{'{16'(k * 3), 16'(k), 1'b1, 16'd1234, 8'd255, 8'd128, 8'd1},
                0, 0, 0, 0, bps_pkg::CLS_NONE});
    for (k = 0; k < 3; k++)
      add_vec('{'{16'(k * 711), 16'(k * 97 + 400), 1'b1, 16'd0, 8'd90, 8'd255, 8'd0},
                0, 0, 0, 0, bps_pkg::CLS_NONE});
    foreach (vec_tbl[i]) begin
      v = vec_tbl[i];
      e = v.has_exp ? shaded_t'({v.r, v.g, v.b, 3'(v.cls)}) : shade_pixel(v.pix);
      send_pixel(v.pix, e);
    end
    in_tvalid <= 1'b0;
    drain();

    // extremes: disabled, then sparsity zero with saturating gains and tiny bricks, then large bricks
    write_reg(bps_pkg::CFG_ENABLE, 48'd0);
    for (k = 0; k < 4; k++) send_checked(rand_pixel(1));
    in_tvalid <= 1'b0;
    drain();
    write_reg(bps_pkg::CFG_ENABLE, 48'd1);
    write_reg(bps_pkg::CFG_SPARSITY, 48'd0);
    write_reg(bps_pkg::CFG_BRICK_WIDTH, 48'd0);
    write_reg(bps_pkg::CFG_BRICK_HEIGHT, 48'd0);
    write_reg(bps_pkg::CFG_MORTAR_SIZE, 48'd15);
    write_reg(bps_pkg::CFG_LONG_LINE, 48'd1000);
    write_reg(bps_pkg::CFG_CLASS_LIMITS, 48'h3FFF_FFFF);
    write_reg(bps_pkg::CFG_COLOR_GAINS, 48'hFFFF_FFFF_FFFF);
    for (k = 0; k < 4; k++) send_checked(rand_pixel(1));
    in_tvalid <= 1'b0;
    drain();
    write_reg(bps_pkg::CFG_BRICK_WIDTH, 48'd255);
    write_reg(bps_pkg::CFG_BRICK_HEIGHT, 48'd255);
    write_reg(bps_pkg::CFG_MORTAR_SIZE, 48'd0);
    write_reg(bps_pkg::CFG_SPARSITY, 48'hFFFF);
    write_reg(bps_pkg::CFG_LONG_LINE, 48'd0);
    write_reg(bps_pkg::CFG_CLASS_LIMITS, 48'({10'd300, 10'd300, 10'd300}));
    for (k = 0; k < 6; k++) send_checked(rand_pixel(1));
    in_tvalid <= 1'b0;
    drain();

    // random phases; the second phase holds the receiver off to back up the pipe
    for (int ph = 0; ph < 10; ph++) begin
      random_cfg();
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (k = 0; k < N_RANDOM / 10; k++) send_checked(rand_pixel(1));
      in_tvalid <= 1'b0;
      drain();
    end

    stim_done = 1'b1;
    k = 0;
    while (pending_q.size() != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0)
      $display("brick_pattern_pixel_shader regression: pass");
    else
      $display("brick_pattern_pixel_shader regression: fail");
    $finish;
  end

endmodule
